// ===== design/ising_pkg.sv =====
// Shared definitions for the Ising Metropolis spin update block.
// Command codes, register indexes and default sizes. No dependencies.
package ising_pkg;

    // Default lattice bound and threshold precision
    localparam int DEF_MAX_SIDE  = 64;
    localparam int DEF_PROB_BITS = 32;

    // Fixed widths of the interface fields
    localparam int CMD_W    = 2;
    localparam int COORD_W  = 6;
    localparam int FRAC_W   = 32;
    localparam int SIDE_W   = 7;
    localparam int DE_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Request commands; the unused code behaves as a read
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRIAL = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIDE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_K1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_K2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_K3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_K4   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

    // Number of ports on the spin store: center plus four neighbors
    localparam int NUM_RD = 5;

endpackage

// ===== design/ising_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for every replica of the spin store.
module ising_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ising_metropolis_spin_update.sv =====
// Ising Metropolis single-spin-flip update, top level.
// A result passes through the stage 1 request register and the result register.
// Throughput: one request per cycle if not stalled, set by the registered read
// of five spin store replicas (center, neighbors) and a one-deep write bypass.
// Reset clears handshake state and configuration; the spin store is not cleared.
// Depends on ising_pkg and ising_ram.
module ising_metropolis_spin_update
    import ising_pkg::*;
#(
    parameter int MAX_SIDE  = DEF_MAX_SIDE,
    parameter int PROB_BITS = DEF_PROB_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data,
    // request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [CMD_W-1:0]           i_command,
    input  logic [COORD_W-1:0]         i_row,
    input  logic [COORD_W-1:0]         i_col,
    input  logic [FRAC_W-1:0]          i_random_fraction,
    input  logic                       i_spin_in,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_spin_out,
    output logic                       o_flipped,
    output logic signed [DE_W-1:0]     o_energy_change,
    output logic                       o_out_of_range
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CMPW  = (SW > SIDE_W) ? SW : SIDE_W;

    // Linear site address within the store
    function automatic logic [AW-1:0] site_addr(input logic [CMPW-1:0] r,
                                                input logic [CMPW-1:0] c);
        logic [AW-1:0] a;
        a = AW'(r) * AW'(MAX_SIDE) + AW'(c);
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0]    r_side;
    logic                 r_periodic;
    logic [PROB_BITS-1:0] r_thr [4];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= SIDE_RESET;
            r_periodic <= 1'b1;
            for (int i = 0; i < 4; i++) begin
                r_thr[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIDE:     r_side     <= i_cfg_data[SIDE_W-1:0];
                REG_PERIODIC: r_periodic <= i_cfg_data[0];
                REG_ACC_K1:   r_thr[0]   <= i_cfg_data[FRAC_W-1 -: PROB_BITS];
                REG_ACC_K2:   r_thr[1]   <= i_cfg_data[FRAC_W-1 -: PROB_BITS];
                REG_ACC_K3:   r_thr[2]   <= i_cfg_data[FRAC_W-1 -: PROB_BITS];
                REG_ACC_K4:   r_thr[3]   <= i_cfg_data[FRAC_W-1 -: PROB_BITS];
                default: ;
            endcase
        end
    end

    // Side clamped to [2, MAX_SIDE]
    logic [CMPW-1:0] side_use;
    always_comb begin
        if (CMPW'(r_side) < CMPW'(2)) begin
            side_use = CMPW'(2);
        end else if (CMPW'(r_side) > CMPW'(MAX_SIDE)) begin
            side_use = CMPW'(MAX_SIDE);
        end else begin
            side_use = CMPW'(r_side);
        end
    end

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_o_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv  = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_acc  = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Stage 0: site and neighbor addresses
    // ------------------------------------------------------------------
    logic [CMPW-1:0] rw, cw;
    logic [CMPW-1:0] r_dn, r_up, c_rt, c_lt;
    logic [3:0]      nb_ok;
    logic            oor;
    logic [AW-1:0]   rd_addr [NUM_RD];

    always_comb begin
        rw   = CMPW'(i_row);
        cw   = CMPW'(i_col);
        oor  = (rw >= side_use) || (cw >= side_use);
        r_dn = (rw + CMPW'(1) == side_use) ? '0 : rw + CMPW'(1);
        r_up = (rw == '0) ? side_use - CMPW'(1) : rw - CMPW'(1);
        c_rt = (cw + CMPW'(1) == side_use) ? '0 : cw + CMPW'(1);
        c_lt = (cw == '0) ? side_use - CMPW'(1) : cw - CMPW'(1);
        // open boundary drops neighbors past an edge
        nb_ok[0] = r_periodic || (rw + CMPW'(1) < side_use);
        nb_ok[1] = r_periodic || (rw != '0);
        nb_ok[2] = r_periodic || (cw + CMPW'(1) < side_use);
        nb_ok[3] = r_periodic || (cw != '0);
        rd_addr[0] = site_addr(rw, cw);
        rd_addr[1] = site_addr(r_dn, cw);
        rd_addr[2] = site_addr(r_up, cw);
        rd_addr[3] = site_addr(rw, c_rt);
        rd_addr[4] = site_addr(rw, c_lt);
    end

    // ------------------------------------------------------------------
    // Spin store replicas and write-back bypass
    // ------------------------------------------------------------------
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic [NUM_RD-1:0] rd_q;
    logic [NUM_RD-1:0] byp_hit;

    for (genvar g = 0; g < NUM_RD; g++) begin : g_store
        ising_ram #(
            .WIDTH (1),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en),
            .i_waddr (wr_addr),
            .i_wdata (wr_data),
            .i_re    (in_acc),
            .i_raddr (rd_addr[g]),
            .o_rdata (rd_q[g])
        );
        // a write landing on the same edge as the read is not seen by the RAM
        assign byp_hit[g] = wr_en && (wr_addr == rd_addr[g]);
    end

    // ------------------------------------------------------------------
    // Stage 1 request register
    // ------------------------------------------------------------------
    logic [CMD_W-1:0]     r_s1_cmd;
    logic                 r_s1_oor;
    logic [AW-1:0]        r_s1_addr;
    logic [PROB_BITS-1:0] r_s1_rnd;
    logic                 r_s1_spin_in;
    logic [3:0]           r_s1_nb_ok;
    logic [NUM_RD-1:0]    r_s1_hit;
    logic                 r_s1_byp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd     <= i_command;
            r_s1_oor     <= oor;
            r_s1_addr    <= rd_addr[0];
            r_s1_rnd     <= i_random_fraction[FRAC_W-1 -: PROB_BITS];
            r_s1_spin_in <= i_spin_in;
            r_s1_nb_ok   <= nb_ok;
            r_s1_hit     <= byp_hit;
            r_s1_byp     <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: Metropolis decision
    // ------------------------------------------------------------------
    logic [NUM_RD-1:0]    spin;
    logic [3:0]           agree, differ;
    logic [2:0]           n_agree, n_differ;
    logic signed [3:0]    k;
    logic [1:0]           thr_sel;
    logic                 trial_flip;
    logic                 n_spin, n_flip;
    logic signed [DE_W-1:0] n_de;

    always_comb begin
        for (int i = 0; i < NUM_RD; i++) begin
            spin[i] = r_s1_hit[i] ? r_s1_byp : rd_q[i];
        end
        for (int i = 0; i < 4; i++) begin
            agree[i]  = r_s1_nb_ok[i] && !(spin[i+1] ^ spin[0]);
            differ[i] = r_s1_nb_ok[i] &&  (spin[i+1] ^ spin[0]);
        end
        n_agree  = 3'(agree[0])  + 3'(agree[1])  + 3'(agree[2])  + 3'(agree[3]);
        n_differ = 3'(differ[0]) + 3'(differ[1]) + 3'(differ[2]) + 3'(differ[3]);
        k        = $signed({1'b0, n_agree}) - $signed({1'b0, n_differ});
        thr_sel  = 2'(k - 4'sd1);
        // downhill or flat always flips; uphill flips by threshold
        trial_flip = (k <= 4'sd0) || (r_s1_rnd < r_thr[thr_sel]);

        n_spin = 1'b0;
        n_flip = 1'b0;
        n_de   = '0;
        wr_en  = 1'b0;
        wr_data = r_s1_spin_in;
        if (!r_s1_oor) begin
            case (r_s1_cmd)
                CMD_WRITE: begin
                    n_spin  = r_s1_spin_in;
                    wr_en   = s1_adv;
                    wr_data = r_s1_spin_in;
                end
                CMD_TRIAL: begin
                    n_flip  = trial_flip;
                    n_spin  = spin[0] ^ trial_flip;
                    n_de    = trial_flip ? $signed({k, 1'b0}) : '0;
                    wr_en   = s1_adv && trial_flip;
                    wr_data = ~spin[0];
                end
                default: begin
                    n_spin = spin[0];
                end
            endcase
        end
    end

    assign wr_addr = r_s1_addr;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                   r_o_spin;
    logic                   r_o_flip;
    logic signed [DE_W-1:0] r_o_de;
    logic                   r_o_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!r_o_valid || i_ready) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_spin <= n_spin;
            r_o_flip <= n_flip;
            r_o_de   <= n_de;
            r_o_oor  <= r_s1_oor;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_spin_out      = r_o_spin;
    assign o_flipped       = r_o_flip;
    assign o_energy_change = r_o_de;
    assign o_out_of_range  = r_o_oor;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the Ising Metropolis spin update block.
// Drives requests and register writes, predicts every result from a private
// copy of the lattice and registers. Depends on ising_pkg and the block's RTL.
module tb;
    import ising_pkg::*;

    // Code 3 is not in the command enum; the block treats it as a read
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        logic                   spin;
        logic                   flipped;
        logic signed [DE_W-1:0] energy_change;
        logic                   out_of_range;
    } t_site_result;

    // Lattice predictor plus in-order store of predicted results
    class ising_lattice_scoreboard;
        bit                lattice [DEF_MAX_SIDE][DEF_MAX_SIDE];
        bit                written [DEF_MAX_SIDE][DEF_MAX_SIDE];
        logic [SIDE_W-1:0] side_reg;
        bit                periodic;
        logic [FRAC_W-1:0] accept_thr [4];
        t_site_result      site_results_due [$];
        int                mismatches;

        function new();
            side_reg = SIDE_RESET;
            periodic = 1'b1;
            foreach (accept_thr[i]) accept_thr[i] = '0;
            mismatches = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_SIDE:     side_reg = data[SIDE_W-1:0];
                REG_PERIODIC: periodic = data[0];
                REG_ACC_K1:   accept_thr[0] = data;
                REG_ACC_K2:   accept_thr[1] = data;
                REG_ACC_K3:   accept_thr[2] = data;
                REG_ACC_K4:   accept_thr[3] = data;
                default: ;
            endcase
        endfunction

        // Sides below 2 act as 2, above the lattice bound as the bound
        function int side_in_use();
            int s;
            s = side_reg;
            if (s < 2) s = 2;
            if (s > DEF_MAX_SIDE) s = DEF_MAX_SIDE;
            return s;
        endfunction

        function int spin_pm(input int r, input int c);
            return lattice[r][c] ? 1 : -1;
        endfunction

        // True when the request reads only sites that already hold a spin
        function bit reads_defined(input logic [CMD_W-1:0] cmd, input int r, input int c);
            int side;
            bit ok;
            side = side_in_use();
            if (r >= side || c >= side) return 1'b1;
            if (cmd == CMD_WRITE) return 1'b1;
            ok = written[r][c];
            if (cmd == CMD_TRIAL) begin
                if (periodic) begin
                    ok = ok && written[(r + 1) % side][c] && written[(r + side - 1) % side][c];
                    ok = ok && written[r][(c + 1) % side] && written[r][(c + side - 1) % side];
                end else begin
                    if (r + 1 < side) ok = ok && written[r + 1][c];
                    if (r > 0) ok = ok && written[r - 1][c];
                    if (c + 1 < side) ok = ok && written[r][c + 1];
                    if (c > 0) ok = ok && written[r][c - 1];
                end
            end
            return ok;
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void note_request(input logic [CMD_W-1:0] cmd,
                                   input logic [COORD_W-1:0] row,
                                   input logic [COORD_W-1:0] col,
                                   input logic [FRAC_W-1:0] frac,
                                   input logic spin_in);
            t_site_result res;
            int side, r, c, sum, k;
            bit flip;
            side = side_in_use();
            r = row;
            c = col;
            res = '0;
            if (r >= side || c >= side) begin
                res.out_of_range = 1'b1;
            end else begin
                if (cmd == CMD_WRITE) begin
                    lattice[r][c] = spin_in;
                    written[r][c] = 1'b1;
                end else if (cmd == CMD_TRIAL) begin
                    sum = 0;
                    if (periodic) begin
                        // with a side of two both neighbors on an axis are one site
                        sum += spin_pm((r + 1) % side, c);
                        sum += spin_pm((r + side - 1) % side, c);
                        sum += spin_pm(r, (c + 1) % side);
                        sum += spin_pm(r, (c + side - 1) % side);
                    end else begin
                        if (r + 1 < side) sum += spin_pm(r + 1, c);
                        if (r > 0) sum += spin_pm(r - 1, c);
                        if (c + 1 < side) sum += spin_pm(r, c + 1);
                        if (c > 0) sum += spin_pm(r, c - 1);
                    end
                    k = spin_pm(r, c) * sum;
                    if (k <= 0) flip = 1'b1;
                    else flip = (frac < accept_thr[k - 1]);
                    if (flip) begin
                        lattice[r][c] = !lattice[r][c];
                        res.flipped = 1'b1;
                        res.energy_change = DE_W'(2 * k);
                    end
                end
                res.spin = lattice[r][c];
            end
            site_results_due.push_back(res);
        endfunction

        function void check_result(input logic spin, input logic flipped,
                                   input logic signed [DE_W-1:0] de,
                                   input logic oor);
            t_site_result exp_res;
            if (site_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with none pending: spin %0b flip %0b de %0d oor %0b",
                             spin, flipped, de, oor);
                return;
            end
            exp_res = site_results_due.pop_front();
            if (spin !== exp_res.spin || flipped !== exp_res.flipped ||
                de !== exp_res.energy_change || oor !== exp_res.out_of_range) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp spin %0b flip %0b de %0d oor %0b, got %0b %0b %0d %0b",
                             exp_res.spin, exp_res.flipped, exp_res.energy_change,
                             exp_res.out_of_range, spin, flipped, de, oor);
            end
        endfunction

        function int results_due();
            return site_results_due.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DAT_W-1:0]   i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic [CMD_W-1:0]       i_command;
    logic [COORD_W-1:0]     i_row;
    logic [COORD_W-1:0]     i_col;
    logic [FRAC_W-1:0]      i_random_fraction;
    logic                   i_spin_in;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_spin_out;
    logic                   o_flipped;
    logic signed [DE_W-1:0] o_energy_change;
    logic                   o_out_of_range;

    ising_lattice_scoreboard sb;
    bit reset_done;
    bit burst_mode;
    int sink_holds_wanted;
    int sink_holds_done;

    ising_metropolis_spin_update uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_row             (i_row),
        .i_col             (i_col),
        .i_random_fraction (i_random_fraction),
        .i_spin_in         (i_spin_in),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_spin_out        (o_spin_out),
        .o_flipped         (o_flipped),
        .o_energy_change   (o_energy_change),
        .o_out_of_range    (o_out_of_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(6, 30);
    endfunction

    // Fractions cluster around the thresholds so the strict compare is hit
    function automatic logic [FRAC_W-1:0] pick_fraction();
        int r;
        logic [FRAC_W-1:0] t;
        r = $urandom_range(0, 99);
        t = sb.accept_thr[$urandom_range(0, 3)];
        if (r < 10) return '0;
        else if (r < 20) return '1;
        else if (r < 45) return t - 1 + $urandom_range(0, 2);
        else return $urandom();
    endfunction

    function automatic logic [FRAC_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        else if (r < 30) return '1;
        else return $urandom();
    endfunction

    // Sometimes anywhere in the field; on larger lattices stay near the edges
    // so wrapped neighbors are hit often
    function automatic int pick_coord(input int side);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 63);
        if (side > 8) begin
            if (r < 6) return $urandom_range(0, 3);
            return side - 1 - int'($urandom_range(0, 3));
        end
        return $urandom_range(0, side - 1);
    endfunction

    // Result sink: random ready gaps plus an occasional long hold-off
    initial begin : result_sink
        int idle;
        i_ready <= 1'b0;
        wait (reset_done);
        forever begin
            @(posedge i_clk);
            if (sink_holds_done != sink_holds_wanted) begin
                sink_holds_done++;
                i_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                idle = burst_mode ? 0 : pick_gap();
                if (idle == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    repeat (idle - 1) @(posedge i_clk);
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (reset_done && o_valid && i_ready)
            sb.check_result(o_spin_out, o_flipped, o_energy_change, o_out_of_range);
    end

    // Watchdog on cycles without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Offer one request, hold it until accepted, then record it
    task automatic send_request(input logic [CMD_W-1:0] cmd, input int row, input int col,
                                input logic [FRAC_W-1:0] frac, input logic spin);
        int idle;
        idle = burst_mode ? 0 : pick_gap();
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_command         <= cmd;
        i_row             <= row[COORD_W-1:0];
        i_col             <= col[COORD_W-1:0];
        i_random_fraction <= frac;
        i_spin_in         <= spin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(cmd, row[COORD_W-1:0], col[COORD_W-1:0], frac, spin);
    endtask

    // Stop sending and let every pending result drain
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.results_due() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    task automatic configure(input int side, input bit periodic,
                             input logic [FRAC_W-1:0] t1, input logic [FRAC_W-1:0] t2,
                             input logic [FRAC_W-1:0] t3, input logic [FRAC_W-1:0] t4);
        wait_idle();
        write_register(REG_SIDE, CFG_DAT_W'(side));
        write_register(REG_PERIODIC, CFG_DAT_W'(periodic));
        write_register(REG_ACC_K1, t1);
        write_register(REG_ACC_K2, t2);
        write_register(REG_ACC_K3, t3);
        write_register(REG_ACC_K4, t4);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic: runs of sequential trials like a sweep, mixed with single requests.
    // A request that would read a site never written becomes a write to that site.
    task automatic run_random_phase(input int count, input bit hold_mid, input bit drain_mid);
        int done, side, r, row, col, run_len;
        bit mid_seen;
        logic [CMD_W-1:0] cmd;
        side = sb.side_in_use();
        done = 0;
        mid_seen = 1'b0;
        while (done < count) begin
            if (!mid_seen && done >= count / 2) begin
                mid_seen = 1'b1;
                if (hold_mid) sink_holds_wanted++;
                if (drain_mid) wait_idle();
            end
            r = $urandom_range(0, 99);
            if (r < 20) begin
                row = pick_coord(side) % side;
                col = pick_coord(side) % side;
                run_len = $urandom_range(4, 16);
                repeat (run_len) begin
                    cmd = CMD_TRIAL;
                    if (!sb.reads_defined(cmd, row, col)) cmd = CMD_WRITE;
                    send_request(cmd, row, col, pick_fraction(), $urandom_range(0, 1));
                    col++;
                    if (col >= side) begin
                        col = 0;
                        row = (row + 1) % side;
                    end
                    done++;
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) cmd = CMD_TRIAL;
                else if (r < 75) cmd = CMD_WRITE;
                else if (r < 93) cmd = CMD_READ;
                else cmd = CMD_UNUSED;
                row = pick_coord(side);
                col = pick_coord(side);
                if (!sb.reads_defined(cmd, row, col)) cmd = CMD_WRITE;
                send_request(cmd, row, col, pick_fraction(), $urandom_range(0, 1));
                done++;
            end
        end
    endtask

    // Main sequence
    initial begin : stimulus
        int phase_sides [12] = '{3, 0, 1, 5, 127, 8, 64, 16, 2, 37, 100, 11};
        logic [FRAC_W-1:0] thr [4];
        sb = new();
        reset_done        = 1'b0;
        burst_mode        = 1'b0;
        sink_holds_wanted = 0;
        sink_holds_done   = 0;
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_command         <= CMD_READ;
        i_row             <= '0;
        i_col             <= '0;
        i_random_fraction <= '0;
        i_spin_in         <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= REG_SIDE;
        i_cfg_data        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_done <= 1'b1;

        // Spins around the corners of the full lattice; other sites get a
        // spin by a write before anything reads them
        for (int r = 0; r < DEF_MAX_SIDE; r++)
            for (int c = 0; c < DEF_MAX_SIDE; c++)
                if ((r < 6 || r >= DEF_MAX_SIDE - 6) && (c < 6 || c >= DEF_MAX_SIDE - 6))
                    send_request(CMD_WRITE, r, c, $urandom(), $urandom_range(0, 1));

        // Reset settings: full side, wrapped edges, zero thresholds
        send_request(CMD_READ, 0, 0, '0, 1'b0);
        send_request(CMD_UNUSED, 63, 63, '1, 1'b1);
        send_request(CMD_TRIAL, 0, 63, '0, 1'b0);
        send_request(CMD_TRIAL, 63, 0, '1, 1'b1);
        // aligned cross: k of four must not flip with a zero threshold
        send_request(CMD_WRITE, 5, 5, '0, 1'b1);
        send_request(CMD_WRITE, 4, 5, '0, 1'b1);
        send_request(CMD_WRITE, 6, 5, '0, 1'b1);
        send_request(CMD_WRITE, 5, 4, '0, 1'b1);
        send_request(CMD_WRITE, 5, 6, '0, 1'b1);
        send_request(CMD_TRIAL, 5, 5, '0, 1'b0);
        // anti-aligned center always flips, energy change at its lowest
        send_request(CMD_WRITE, 5, 5, '1, 1'b0);
        send_request(CMD_TRIAL, 5, 5, '1, 1'b0);

        // Side of two with wrap: each neighbor counted twice; full thresholds
        configure(2, 1'b1, '1, '1, '1, '1);
        send_request(CMD_WRITE, 0, 0, '0, 1'b1);
        send_request(CMD_WRITE, 0, 1, '0, 1'b1);
        send_request(CMD_WRITE, 1, 0, '0, 1'b1);
        send_request(CMD_WRITE, 1, 1, '0, 1'b1);
        send_request(CMD_TRIAL, 0, 0, '0, 1'b0);
        send_request(CMD_TRIAL, 0, 0, '1, 1'b1);
        send_request(CMD_TRIAL, 1, 1, '1, 1'b0);
        // out-of-range sites change nothing
        send_request(CMD_WRITE, 2, 0, '0, 1'b0);
        send_request(CMD_READ, 0, 63, '0, 1'b1);
        send_request(CMD_TRIAL, 63, 63, '0, 1'b1);

        // Random phases across sides, boundaries and thresholds
        for (int p = 0; p < 12; p++) begin
            foreach (thr[i]) thr[i] = pick_threshold();
            if (p == 2) foreach (thr[i]) thr[i] = '0;
            if (p == 4) foreach (thr[i]) thr[i] = '1;
            configure(phase_sides[p], p[0], thr[0], thr[1], thr[2], thr[3]);
            burst_mode = (p % 4 == 3);
            run_random_phase(150, p == 1 || p == 6, p == 5);
        end
        burst_mode = 1'b0;

        // Drain and report
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.results_due() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
